// ===== sv/mrg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator package
// Shared types, payload structs, register indexes and control codes.
// ----------------------------------------------------------------------------
package mrg_pkg;

    localparam int LABEL_W = 5;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 16;
    localparam int RRAND_W = 31;
    localparam int WALL_W  = 32;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 16;

    localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd0;
    localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd1;

    localparam logic [COL_W-1:0] NUM_COLS_RESET = 6'd32;
    localparam logic [ROW_W-1:0] NUM_ROWS_RESET = 16'd32;
    localparam logic [COL_W-1:0] MIN_COLS       = 6'd2;

    typedef struct packed {
        logic [RRAND_W-1:0] right_random;
        logic [WALL_W-1:0]  bottom_random;
    } in_item_t;

    typedef struct packed {
        logic [WALL_W-1:0] right_walls;
        logic [WALL_W-1:0] bottom_walls;
        logic [ROW_W-1:0]  row_index;
        logic              last_row;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CFG_W-1:0] value;
    } cfg_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FRESH,
        ST_MINIT,
        ST_MERGE,
        ST_BINIT,
        ST_BOTTOM,
        ST_LINIT,
        ST_LMERGE,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FRESH,
        OP_MINIT,
        OP_MERGE,
        OP_BINIT,
        OP_BOTTOM,
        OP_LINIT,
        OP_LMERGE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic col_end;
        logic merge_end;
        logic last;
        logic out_free;
    } status_t;

endpackage

// ===== sv/mrg_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator stream channel
// Valid/ready channel carrying one payload struct per transaction.
// ----------------------------------------------------------------------------
interface mrg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mrg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator controller
// Sequences the relabel, merge, bottom wall and final merge column passes.
// ----------------------------------------------------------------------------
module mrg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mrg_pkg::status_t status,
    output mrg_pkg::cmd_t    cmd
);

    mrg_pkg::state_t state_reg;
    mrg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mrg_pkg::ST_FRESH;
                end
            end
            mrg_pkg::ST_FRESH:
            begin
                if (status.col_end)
                begin
                    state_next = mrg_pkg::ST_MINIT;
                end
            end
            mrg_pkg::ST_MINIT:
            begin
                state_next = mrg_pkg::ST_MERGE;
            end
            mrg_pkg::ST_MERGE:
            begin
                if (status.merge_end)
                begin
                    state_next = mrg_pkg::ST_BINIT;
                end
            end
            mrg_pkg::ST_BINIT:
            begin
                // final row: bottom walls are all set, go join the sets
                state_next = status.last ? mrg_pkg::ST_LINIT : mrg_pkg::ST_BOTTOM;
            end
            mrg_pkg::ST_BOTTOM:
            begin
                if (status.col_end)
                begin
                    state_next = mrg_pkg::ST_EMIT;
                end
            end
            mrg_pkg::ST_LINIT:
            begin
                state_next = mrg_pkg::ST_LMERGE;
            end
            mrg_pkg::ST_LMERGE:
            begin
                if (status.merge_end)
                begin
                    state_next = mrg_pkg::ST_EMIT;
                end
            end
            mrg_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = mrg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = mrg_pkg::OP_NONE;
        unique case (state_reg)
            mrg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = mrg_pkg::OP_LOAD;
                end
            end
            mrg_pkg::ST_FRESH:  cmd.op = mrg_pkg::OP_FRESH;
            mrg_pkg::ST_MINIT:  cmd.op = mrg_pkg::OP_MINIT;
            mrg_pkg::ST_MERGE:  cmd.op = mrg_pkg::OP_MERGE;
            mrg_pkg::ST_BINIT:  cmd.op = mrg_pkg::OP_BINIT;
            mrg_pkg::ST_BOTTOM: cmd.op = mrg_pkg::OP_BOTTOM;
            mrg_pkg::ST_LINIT:  cmd.op = mrg_pkg::OP_LINIT;
            mrg_pkg::ST_LMERGE: cmd.op = mrg_pkg::OP_LMERGE;
            mrg_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = mrg_pkg::OP_EMIT;
                end
            end
            default:
            begin
                cmd.op = mrg_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ===== sv/mrg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator datapath
// Set labels, wall masks, row state, configuration and the output register.
// ----------------------------------------------------------------------------
module mrg_datapath #(
    parameter int MAX_COLS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrg_pkg::cmd_t       cmd,
    output mrg_pkg::status_t    status,
    input  mrg_pkg::in_item_t   in_item,
    input  logic                cfg_valid,
    input  mrg_pkg::cfg_item_t  cfg_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mrg_pkg::out_item_t  out_item
);

    localparam int IW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;

    logic [mrg_pkg::COL_W-1:0]   num_cols_reg;
    logic [mrg_pkg::ROW_W-1:0]   num_rows_reg;
    logic [mrg_pkg::LABEL_W-1:0] labels_reg [MAX_COLS];
    logic [MAX_COLS-1:0]         prev_bottom_reg;
    logic [mrg_pkg::ROW_W-1:0]   row_counter_reg;
    logic [MAX_COLS-1:0]         fresh_reg;
    logic [MAX_COLS-1:0]         right_reg;
    logic [MAX_COLS-1:0]         bottom_reg;
    logic [mrg_pkg::RRAND_W-1:0] rrand_reg;
    logic [mrg_pkg::WALL_W-1:0]  brand_reg;
    logic [mrg_pkg::COL_W-1:0]   cols_reg;
    logic                        last_reg;
    logic [IW-1:0]               j_reg;
    logic [mrg_pkg::LABEL_W-1:0] keep_reg;
    logic                        out_valid_reg;
    mrg_pkg::out_item_t          out_reg;

    logic [mrg_pkg::COL_W-1:0]   cols_clamped;
    logic [MAX_COLS-1:0]         in_use;
    logic [IW-1:0]               j_plus;
    logic [mrg_pkg::LABEL_W-1:0] gone;
    logic [mrg_pkg::LABEL_W-1:0] label_j;
    logic [mrg_pkg::WALL_W-1:0]  used;
    logic [mrg_pkg::LABEL_W-1:0] fresh_label;
    logic [MAX_COLS-1:0]         open_vec;
    logic                        multi_open;
    logic                        do_merge;
    logic [mrg_pkg::ROW_W:0]     row_plus;

    always_comb
    begin
        if (num_cols_reg < mrg_pkg::MIN_COLS)
        begin
            cols_clamped = mrg_pkg::MIN_COLS;
        end
        else if (num_cols_reg > mrg_pkg::COL_W'(MAX_COLS))
        begin
            cols_clamped = mrg_pkg::COL_W'(MAX_COLS);
        end
        else
        begin
            cols_clamped = num_cols_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_COLS; k++)
        begin
            in_use[k] = mrg_pkg::COL_W'(k) < cols_reg;
        end
    end

    assign j_plus  = j_reg + 1'b1;
    assign gone    = labels_reg[j_plus];
    assign label_j = labels_reg[j_reg];

    // smallest label not held by a labelled column in use
    always_comb
    begin
        used = '0;
        for (int k = 0; k < MAX_COLS; k++)
        begin
            if (in_use[k] && !fresh_reg[k])
            begin
                used[labels_reg[k]] = 1'b1;
            end
        end
        fresh_label = mrg_pkg::LABEL_W'(31);
        for (int i = 30; i >= 0; i--)
        begin
            if (!used[i])
            begin
                fresh_label = mrg_pkg::LABEL_W'(i);
            end
        end
    end

    // open cells sharing column j's set; keep the bit only if two or more
    always_comb
    begin
        for (int k = 0; k < MAX_COLS; k++)
        begin
            open_vec[k] = in_use[k] && (labels_reg[k] == label_j) && !bottom_reg[k];
        end
        multi_open = |(open_vec & (open_vec - 1'b1));
    end

    always_comb
    begin
        if (cmd.op == mrg_pkg::OP_LMERGE)
        begin
            do_merge = right_reg[j_reg] && (keep_reg != gone);
        end
        else
        begin
            do_merge = !rrand_reg[j_reg] && (keep_reg != gone);
        end
    end

    assign row_plus = {1'b0, row_counter_reg} + 1'b1;

    assign status.col_end   = ({{(mrg_pkg::COL_W-IW){1'b0}}, j_reg} + 1'b1) == cols_reg;
    assign status.merge_end = ({{(mrg_pkg::COL_W-IW){1'b0}}, j_reg} + 2'd2) == cols_reg;
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= mrg_pkg::NUM_COLS_RESET;
            num_rows_reg <= mrg_pkg::NUM_ROWS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_item.index == mrg_pkg::REG_NUM_COLS)
            begin
                num_cols_reg <= cfg_item.value[mrg_pkg::COL_W-1:0];
            end
            else if (cfg_item.index == mrg_pkg::REG_NUM_ROWS)
            begin
                num_rows_reg <= cfg_item.value;
            end
        end
    end

    // row state and set labels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_COLS; k++)
            begin
                labels_reg[k] <= '0;
            end
            prev_bottom_reg <= '1;
            row_counter_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                mrg_pkg::OP_FRESH:
                begin
                    if (fresh_reg[j_reg])
                    begin
                        labels_reg[j_reg] <= fresh_label;
                    end
                end
                mrg_pkg::OP_MERGE, mrg_pkg::OP_LMERGE:
                begin
                    if (do_merge)
                    begin
                        for (int k = 0; k < MAX_COLS; k++)
                        begin
                            if (in_use[k] && labels_reg[k] == gone)
                            begin
                                labels_reg[k] <= keep_reg;
                            end
                        end
                    end
                end
                mrg_pkg::OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    if (last_reg)
                    begin
                        row_counter_reg <= '0;
                        prev_bottom_reg <= '1;
                    end
                    else
                    begin
                        row_counter_reg <= row_plus[mrg_pkg::ROW_W-1:0];
                        prev_bottom_reg <= (bottom_reg & in_use) | ~in_use;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-row working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            mrg_pkg::OP_LOAD:
            begin
                rrand_reg <= in_item.right_random;
                brand_reg <= in_item.bottom_random;
                cols_reg  <= cols_clamped;
                last_reg  <= row_plus >= {1'b0, num_rows_reg};
                for (int k = 0; k < MAX_COLS; k++)
                begin
                    fresh_reg[k] <= prev_bottom_reg[k] &&
                                    (mrg_pkg::COL_W'(k) < cols_clamped);
                end
                j_reg <= '0;
            end
            mrg_pkg::OP_FRESH:
            begin
                fresh_reg[j_reg] <= 1'b0;
                j_reg <= j_plus;
            end
            mrg_pkg::OP_MINIT:
            begin
                keep_reg  <= labels_reg[0];
                right_reg <= '0;
                j_reg     <= '0;
            end
            mrg_pkg::OP_MERGE:
            begin
                if (!do_merge)
                begin
                    right_reg[j_reg] <= 1'b1;
                    keep_reg <= gone;
                end
                j_reg <= j_plus;
            end
            mrg_pkg::OP_BINIT:
            begin
                right_reg[cols_reg[IW-1:0] - 1'b1] <= 1'b1;
                bottom_reg <= last_reg ? in_use : '0;
                j_reg <= '0;
            end
            mrg_pkg::OP_BOTTOM:
            begin
                if (multi_open && brand_reg[j_reg])
                begin
                    bottom_reg[j_reg] <= 1'b1;
                end
                j_reg <= j_plus;
            end
            mrg_pkg::OP_LINIT:
            begin
                keep_reg <= labels_reg[0];
                j_reg    <= '0;
            end
            mrg_pkg::OP_LMERGE:
            begin
                if (do_merge)
                begin
                    right_reg[j_reg] <= 1'b0;
                end
                else
                begin
                    keep_reg <= gone;
                end
                j_reg <= j_plus;
            end
            mrg_pkg::OP_EMIT:
            begin
                out_reg.right_walls  <= mrg_pkg::WALL_W'(right_reg & in_use);
                out_reg.bottom_walls <= mrg_pkg::WALL_W'(bottom_reg & in_use);
                out_reg.row_index    <= row_counter_reg;
                out_reg.last_row     <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== sv/maze_row_generator_top.sv =====
`timescale 1ns / 1ps
// A new row is taken only while idle, once the previous row has moved into
// the output register, so rows are not overlapped in the datapath.
// The relabel, merge, bottom wall and final merge passes each take one column
// per cycle in the shared datapath. A finished row waits in the output
// register while the next transaction is taken. Reset clears the labels, marks
// the previous bottom walls all set and restarts at row zero.
// ----------------------------------------------------------------------------
// Maze row generator top level
// Eller's maze rows, one row of wall masks per input transaction.
// ----------------------------------------------------------------------------
module maze_row_generator_top #(
    parameter int MAX_COLS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    mrg_stream_if.sink in_ch,
    mrg_stream_if.source out_ch,
    mrg_stream_if.sink cfg_ch
);

    mrg_pkg::cmd_t    cmd;
    mrg_pkg::status_t status;

    assign cfg_ch.ready = 1'b1;

    mrg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mrg_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_ch.data),
        .cfg_valid (cfg_ch.valid),
        .cfg_item  (cfg_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.data)
    );

endmodule

// ===== tb/mrg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator checker
// Watches the row, result and register channels. It keeps its own copy of the
// set labels, previous bottom walls, row count and registers, predicts every
// row and compares each result field by field in order.
// ----------------------------------------------------------------------------
module mrg_checker
    import mrg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mrg_stream_if in_ch,
    mrg_stream_if out_ch,
    mrg_stream_if cfg_ch,
    output int    failures,
    output int    pending
);

    logic [COL_W-1:0]   cols_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [LABEL_W-1:0] labels [WALL_W];
    logic [WALL_W-1:0]  prev_bottom;
    logic [ROW_W-1:0]   row_count;
    out_item_t          expected_rows [$];

    function automatic void join_sets(int width, int j);
        logic [LABEL_W-1:0] keep;
        logic [LABEL_W-1:0] gone;
        keep = labels[j];
        gone = labels[j+1];
        for (int k = 0; k < width; k++)
            if (labels[k] == gone)
                labels[k] = keep;
    endfunction

    function automatic out_item_t build_row(in_item_t item);
        int                width;
        logic              last;
        logic [WALL_W-1:0] fresh;
        logic [WALL_W-1:0] used;
        logic [WALL_W-1:0] right;
        logic [WALL_W-1:0] bottom;
        logic [WALL_W-1:0] colmask;
        int                lab;
        int                open_cells;
        out_item_t         res;
        width = (cols_reg < MIN_COLS) ? 2 : (cols_reg > 32) ? 32 : int'(cols_reg);
        last = (32'(row_count) + 1 >= 32'(rows_reg));
        colmask = (width == 32) ? '1 : ((32'd1 << width) - 1);
        right = '0;
        bottom = '0;
        fresh = prev_bottom;
        // relabel columns under a wall with the smallest free label
        for (int j = 0; j < width; j++) begin
            if (fresh[j]) begin
                used = '0;
                for (int k = 0; k < width; k++)
                    if (!fresh[k])
                        used[labels[k]] = 1'b1;
                lab = 0;
                while (lab < 31 && used[lab])
                    lab++;
                labels[j] = LABEL_W'(lab);
                fresh[j] = 1'b0;
            end
        end
        for (int j = 0; j + 1 < width; j++) begin
            if (!item.right_random[j] && labels[j] != labels[j+1])
                join_sets(width, j);
            else
                right[j] = 1'b1;
        end
        right[width-1] = 1'b1;
        // final row: wall every cell; otherwise keep the last open cell of each set open
        for (int j = 0; j < width; j++) begin
            if (last) begin
                bottom[j] = 1'b1;
            end
            else begin
                open_cells = 0;
                for (int k = 0; k < width; k++)
                    if (labels[k] == labels[j] && !bottom[k])
                        open_cells++;
                if (open_cells > 1 && item.bottom_random[j])
                    bottom[j] = 1'b1;
            end
        end
        if (last) begin
            for (int j = 0; j + 1 < width; j++) begin
                if (right[j] && labels[j] != labels[j+1]) begin
                    right[j] = 1'b0;
                    join_sets(width, j);
                end
            end
        end
        res.right_walls = right & colmask;
        res.bottom_walls = bottom & colmask;
        res.row_index = row_count;
        res.last_row = last;
        if (last) begin
            row_count = '0;
            prev_bottom = '1;
        end
        else begin
            row_count = row_count + 1'b1;
            prev_bottom = (bottom & colmask) | ~colmask;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [WALL_W-1:0] exp_v,
                                        logic [WALL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t exp_row;
        if (!rst_n) begin
            cols_reg = NUM_COLS_RESET;
            rows_reg = NUM_ROWS_RESET;
            for (int k = 0; k < WALL_W; k++)
                labels[k] = '0;
            prev_bottom = '1;
            row_count = '0;
            expected_rows.delete();
            failures = 0;
        end
        else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.data.index == REG_NUM_COLS)
                    cols_reg = COL_W'(cfg_ch.data.value);
                else if (cfg_ch.data.index == REG_NUM_ROWS)
                    rows_reg = cfg_ch.data.value;
            end
            if (in_ch.valid && in_ch.ready)
                expected_rows.push_back(build_row(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row, expected none, actual %h", $time,
                             out_ch.data);
                    failures++;
                end
                else begin
                    exp_row = expected_rows.pop_front();
                    check_field("right_walls", exp_row.right_walls,
                                out_ch.data.right_walls);
                    check_field("bottom_walls", exp_row.bottom_walls,
                                out_ch.data.bottom_walls);
                    check_field("row_index", 32'(exp_row.row_index),
                                32'(out_ch.data.row_index));
                    check_field("last_row", 32'(exp_row.last_row),
                                32'(out_ch.data.last_row));
                end
            end
        end
        pending = expected_rows.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze row generator testbench
// Drives directed and random rows in bursts across many column and row
// counts, stalls the result side, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 120;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   cycles;
    int   burst_left;
    bit   long_hold;

    mrg_stream_if #(.payload_t(mrg_pkg::in_item_t))  in_ch ();
    mrg_stream_if #(.payload_t(mrg_pkg::out_item_t)) out_ch ();
    mrg_stream_if #(.payload_t(mrg_pkg::cfg_item_t)) cfg_ch ();

    maze_row_generator_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    mrg_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_ch   (cfg_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: switch between stall patterns, with one long hold-off
    initial
    begin
        int mode;
        int stretch;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(10, 300);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (800) @(posedge clk);
                long_hold = 1'b0;
            end
            repeat (stretch)
            begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= $urandom_range(0, 1);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic [mrg_pkg::WALL_W-1:0] random_bits();
        case ($urandom_range(0, 4))
            0: return $urandom & $urandom & $urandom;
            1: return $urandom | $urandom | $urandom;
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(logic [mrg_pkg::RRAND_W-1:0] rr, logic [mrg_pkg::WALL_W-1:0] br);
        mrg_pkg::in_item_t item;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        item.right_random = rr;
        item.bottom_random = br;
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
    endtask

    // wait for every row, then for one more row time in case the block is busy
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [mrg_pkg::IDX_W-1:0] idx,
                             logic [mrg_pkg::CFG_W-1:0] value);
        mrg_pkg::cfg_item_t w;
        w.index = idx;
        w.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_shape(logic [mrg_pkg::CFG_W-1:0] cols,
                             logic [mrg_pkg::CFG_W-1:0] rows);
        write_reg(mrg_pkg::REG_NUM_COLS, cols);
        write_reg(mrg_pkg::REG_NUM_ROWS, rows);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [mrg_pkg::CFG_W-1:0] col_set [10];
        logic [mrg_pkg::CFG_W-1:0] row_set [10];
        col_set = '{2, 32, 0, 1, 33, 63, 5, 32, 3, 17};
        row_set = '{1, 0, 2, 65535, 3, 1, 7, 4, 65535, 2};
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        cycles = 0;
        burst_left = 0;
        long_hold = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset shape: extremes, alternating, single-bit and half-word patterns
        send_row('0, '0);
        send_row('1, '1);
        send_row('0, '1);
        send_row('1, '0);
        send_row(31'h55555555, 32'hAAAAAAAA);
        send_row(31'h2AAAAAAA, 32'h55555555);
        send_row(31'h00000001, 32'h80000000);
        send_row(31'h40000000, 32'h00000001);
        send_row(31'h0000FFFF, 32'hFFFF0000);
        send_row(31'h7FFF0000, 32'h0000FFFF);
        wait_idle();
        set_shape(16'd2, 16'd1);
        send_row('0, '0);
        send_row('1, '1);
        wait_idle();
        set_shape(16'd4, 16'd0);
        send_row('0, '1);
        send_row(31'h5, 32'hA);
        wait_idle();

        for (int p = 0; p < 20; p++)
        begin
            if (p < 10)
                set_shape(col_set[p], row_set[p]);
            else if ($urandom_range(0, 3) == 0)
                set_shape(mrg_pkg::CFG_W'($urandom_range(0, 63)),
                          mrg_pkg::CFG_W'($urandom_range(0, 65535)));
            else
                set_shape(mrg_pkg::CFG_W'($urandom_range(2, 32)),
                          mrg_pkg::CFG_W'($urandom_range(1, 12)));
            if (p == 12)
                long_hold = 1'b1;
            repeat (54)
                send_row(mrg_pkg::RRAND_W'(random_bits()), random_bits());
            wait_idle();
        end

        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
